[src/layered_circuit_path_count_max_assert.svh]
// Assertion helpers shared by the path counter modules.
`ifndef LAYERED_CIRCUIT_PATH_COUNT_MAX_ASSERT_SVH
`define LAYERED_CIRCUIT_PATH_COUNT_MAX_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define LCPC_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LCPC_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/lcpc_pkg.sv]
package lcpc_pkg;

  // Default sizing
  localparam int MAX_INPUTS_DEF = 16;
  localparam int MAX_DEPTH_DEF  = 8;
  localparam int MAX_WIDTH_DEF  = 16;
  localparam int COUNT_BITS_DEF = 16;

  // Fixed field widths
  localparam int LAYER_W  = 3;
  localparam int GATE_W   = 4;
  localparam int PARENT_W = 4;
  localparam int INDEX_W  = 4;
  localparam int RESULT_W = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_INPUTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH      = 2'd2;

  localparam logic [4:0] NUM_INPUTS_RST = 5'd5;
  localparam logic [3:0] DEPTH_RST      = 4'd3;
  localparam logic [4:0] WIDTH_RST      = 5'd3;

  // Request kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Control lines into the count store
  typedef struct packed {
    logic rd;
    logic wr;
    logic clear;
  } cnt_cmd_t;

  // Address bits for a store of the given depth, at least one
  function automatic int addr_bits(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

[src/lcpc_ram.sv]
module lcpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = lcpc_pkg::addr_bits(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port (read-first)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/lcpc_count_store.sv]
`include "layered_circuit_path_count_max_assert.svh"

module lcpc_count_store #(
  parameter int COUNT_BITS = lcpc_pkg::COUNT_BITS_DEF,
  parameter int SLOTS      = 144,
  localparam int CA_W = lcpc_pkg::addr_bits(SLOTS)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lcpc_pkg::cnt_cmd_t    cmd,
  input  logic [CA_W-1:0]       rd_addr,
  input  logic [CA_W-1:0]       wr_addr,
  input  logic [COUNT_BITS-1:0] wr_data,
  output logic [COUNT_BITS-1:0] rd_data
);

  logic [SLOTS-1:0]      valid;
  logic                  rd_valid;
  logic [COUNT_BITS-1:0] ram_q;

  lcpc_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.wr),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (cmd.rd),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // Per-slot valid bits; a slot never written since the last clear reads zero
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      valid <= '0;
    end else if (cmd.wr) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (cmd.rd) begin
      rd_valid <= valid[rd_addr];
    end
  end

  assign rd_data = rd_valid ? ram_q : '0;

  `LCPC_ASSERT_SAME(a_clear_alone, clk, rst, cmd.clear, !cmd.wr && !cmd.rd, "count clear overlaps an access")
  `LCPC_ASSERT_NEXT(a_clear_empties, clk, rst, cmd.clear, valid == '0, "valid bits survive a clear")
  `LCPC_ASSERT_NEXT(a_write_marks, clk, rst, cmd.wr && !cmd.clear, valid[$past(wr_addr)], "written slot not marked valid")

endmodule

[src/layered_circuit_path_count_max.sv]
// Layered circuit path counter, max path count to a primary input.
// Load: taken on start while idle, no result. Query: one result strobe on done.
// Depth one or an out-of-range output gate: result in the cycle after start.
// Otherwise a walk from the top gate down, then a scan of the inputs;
//   busy holds the next request off until the strobe.
// Reset: registers to 5 / 3 / 3, idle; gate parents undefined until loaded.
`include "layered_circuit_path_count_max_assert.svh"

module layered_circuit_path_count_max #(
  parameter int MAX_INPUTS = lcpc_pkg::MAX_INPUTS_DEF,
  parameter int MAX_DEPTH  = lcpc_pkg::MAX_DEPTH_DEF,
  parameter int MAX_WIDTH  = lcpc_pkg::MAX_WIDTH_DEF,
  parameter int COUNT_BITS = lcpc_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            kind,
  input  logic [lcpc_pkg::LAYER_W-1:0]    layer,
  input  logic [lcpc_pkg::GATE_W-1:0]     gate,
  input  logic [lcpc_pkg::PARENT_W-1:0]   parent_a,
  input  logic [lcpc_pkg::PARENT_W-1:0]   parent_b,
  input  logic [lcpc_pkg::INDEX_W-1:0]    output_index,
  output logic                            done,
  output logic [lcpc_pkg::RESULT_W-1:0]   max_paths,
  input  logic                            cfg_we,
  input  logic [lcpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lcpc_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int GATE_SLOTS  = MAX_DEPTH * MAX_WIDTH;
  localparam int COUNT_SLOTS = MAX_INPUTS + GATE_SLOTS;
  localparam int GA_W = lcpc_pkg::addr_bits(GATE_SLOTS);
  localparam int CA_W = lcpc_pkg::addr_bits(COUNT_SLOTS);
  localparam int N_W  = $clog2(MAX_INPUTS + 1);
  localparam int D_W  = $clog2(MAX_DEPTH + 1);
  localparam int W_W  = $clog2(MAX_WIDTH + 1);
  localparam int L_W  = lcpc_pkg::addr_bits(MAX_DEPTH);
  localparam int G_W  = lcpc_pkg::addr_bits(MAX_WIDTH);
  localparam int I_W  = lcpc_pkg::addr_bits(MAX_INPUTS);
  localparam int PT_W = 2 * lcpc_pkg::PARENT_W;
  localparam int PW   = lcpc_pkg::PARENT_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_GATE  = 3'd1;
  localparam logic [2:0] S_PA    = 3'd2;
  localparam logic [2:0] S_PAW   = 3'd3;
  localparam logic [2:0] S_PBW   = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;
  localparam logic [2:0] S_DRAIN = 3'd6;

  function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] x,
                                                    input logic [COUNT_BITS-1:0] y);
    logic [COUNT_BITS:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
  endfunction

  // Count slot of parent p of a gate in layer lay; ok is low when p is out of range
  function automatic logic [CA_W:0] parent_slot(input logic [L_W-1:0] lay,
                                                input logic [PW-1:0]  p,
                                                input logic [N_W-1:0] n,
                                                input logic [W_W-1:0] w);
    logic          ok;
    logic [CA_W-1:0] slot;
    if (lay == '0) begin
      ok   = 32'(p) < 32'(n);
      slot = CA_W'(p);
    end else begin
      ok   = 32'(p) < 32'(w);
      slot = CA_W'(MAX_INPUTS + (32'(lay) - 1) * MAX_WIDTH + 32'(p));
    end
    return {ok, slot};
  endfunction

  // Configuration registers
  logic [4:0] num_inputs;
  logic [3:0] depth;
  logic [4:0] width_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_inputs   <= lcpc_pkg::NUM_INPUTS_RST;
      depth        <= lcpc_pkg::DEPTH_RST;
      width_in_use <= lcpc_pkg::WIDTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lcpc_pkg::REG_NUM_INPUTS: num_inputs   <= cfg_data;
        lcpc_pkg::REG_DEPTH:      depth        <= cfg_data[3:0];
        lcpc_pkg::REG_WIDTH:      width_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamped register values
  logic [N_W-1:0] n_clamp;
  logic [D_W-1:0] d_clamp;
  logic [W_W-1:0] w_clamp;

  always_comb begin
    if (num_inputs == '0) begin
      n_clamp = N_W'(1);
    end else if (32'(num_inputs) > MAX_INPUTS) begin
      n_clamp = N_W'(MAX_INPUTS);
    end else begin
      n_clamp = N_W'(num_inputs);
    end
    if (depth == '0) begin
      d_clamp = D_W'(1);
    end else if (32'(depth) > MAX_DEPTH) begin
      d_clamp = D_W'(MAX_DEPTH);
    end else begin
      d_clamp = D_W'(depth);
    end
    if (width_in_use == '0) begin
      w_clamp = W_W'(1);
    end else if (32'(width_in_use) > MAX_WIDTH) begin
      w_clamp = W_W'(MAX_WIDTH);
    end else begin
      w_clamp = W_W'(width_in_use);
    end
  end

  // Sequencer state
  logic [2:0]            state;
  logic [N_W-1:0]        n_q;
  logic [W_W-1:0]        w_q;
  logic [L_W-1:0]        cur_lay;
  logic [G_W-1:0]        cur_g;
  logic                  top;
  logic [COUNT_BITS-1:0] v;
  logic                  a_ok;
  logic                  b_ok;
  logic                  same;
  logic [CA_W-1:0]       a_slot;
  logic [CA_W-1:0]       b_slot;
  logic [COUNT_BITS-1:0] a_sum;
  logic [I_W-1:0]        scan_idx;
  logic                  cmp_pend;
  logic [COUNT_BITS-1:0] best;

  logic                  accept;
  logic                  out_ok;
  logic [GA_W-1:0]       gate_addr;
  logic [CA_W-1:0]       own_slot;
  logic [PT_W-1:0]       pt_q;
  logic                  pt_we;
  logic [GA_W-1:0]       pt_waddr;
  logic [CA_W:0]         a_info;
  logic [CA_W:0]         b_info;
  logic [COUNT_BITS-1:0] v_in;
  logic [COUNT_BITS-1:0] sum_a;
  logic [COUNT_BITS-1:0] sum_b;
  logic [COUNT_BITS-1:0] best_fin;
  logic                  last_gate;
  logic                  last_scan;

  lcpc_pkg::cnt_cmd_t    cnt_cmd;
  logic [CA_W-1:0]       cnt_raddr;
  logic [CA_W-1:0]       cnt_waddr;
  logic [COUNT_BITS-1:0] cnt_wdata;
  logic [COUNT_BITS-1:0] cnt_q;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign out_ok = 32'(output_index) < 32'(w_clamp);

  // Load addressing
  assign pt_we    = accept && (kind == lcpc_pkg::KIND_LOAD) &&
                    (32'(layer) < MAX_DEPTH) && (32'(gate) < MAX_WIDTH);
  assign pt_waddr = GA_W'(32'(layer) * MAX_WIDTH + 32'(gate));

  // Gate being walked
  assign gate_addr = GA_W'(32'(cur_lay) * MAX_WIDTH + 32'(cur_g));
  assign own_slot  = CA_W'(MAX_INPUTS + 32'(gate_addr));

  assign a_info = parent_slot(cur_lay, pt_q[PW-1:0], n_q, w_q);
  assign b_info = parent_slot(cur_lay, pt_q[PT_W-1:PW], n_q, w_q);
  assign v_in   = top ? COUNT_BITS'(1) : cnt_q;
  assign sum_a  = sat_add(cnt_q, v);
  assign sum_b  = sat_add(same ? a_sum : cnt_q, v);
  assign best_fin  = (cnt_q > best) ? cnt_q : best;
  assign last_gate = (32'(cur_g) == 32'(w_q) - 1);
  assign last_scan = (32'(scan_idx) == 32'(n_q) - 1);

  lcpc_ram #(
    .WIDTH (PT_W),
    .DEPTH (GATE_SLOTS)
  ) u_parent_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_waddr),
    .wdata ({parent_b, parent_a}),
    .re    (state == S_GATE),
    .raddr (gate_addr),
    .rdata (pt_q)
  );

  lcpc_count_store #(
    .COUNT_BITS (COUNT_BITS),
    .SLOTS      (COUNT_SLOTS)
  ) u_counts (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cnt_cmd),
    .rd_addr (cnt_raddr),
    .wr_addr (cnt_waddr),
    .wr_data (cnt_wdata),
    .rd_data (cnt_q)
  );

  // Count store requests per state
  always_comb begin
    cnt_cmd   = '0;
    cnt_raddr = '0;
    cnt_waddr = '0;
    cnt_wdata = '0;
    unique case (state)
      S_IDLE: begin
        cnt_cmd.clear = accept && (kind == lcpc_pkg::KIND_QUERY);
      end
      S_GATE: begin
        cnt_cmd.rd = !top;
        cnt_raddr  = own_slot;
      end
      S_PA: begin
        cnt_cmd.rd = (v_in != '0);
        cnt_raddr  = a_info[CA_W-1:0];
      end
      S_PAW: begin
        cnt_cmd.wr = a_ok;
        cnt_waddr  = a_slot;
        cnt_wdata  = sum_a;
        cnt_cmd.rd = 1'b1;
        cnt_raddr  = b_slot;
      end
      S_PBW: begin
        cnt_cmd.wr = b_ok;
        cnt_waddr  = b_slot;
        cnt_wdata  = sum_b;
      end
      S_SCAN: begin
        cnt_cmd.rd = 1'b1;
        cnt_raddr  = CA_W'(scan_idx);
      end
      S_DRAIN: ;
      default: ;
    endcase
  end

  // Sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      done     <= 1'b0;
      cmp_pend <= 1'b0;
    end else begin
      cmp_pend <= (state == S_SCAN);
      // strobe: short query answered at once, or walk finished
      done     <= (state == S_DRAIN) ||
                  (accept && (kind == lcpc_pkg::KIND_QUERY) &&
                   ((d_clamp == D_W'(1)) || !out_ok));
      unique case (state)
        S_IDLE: begin
          if (accept && (kind == lcpc_pkg::KIND_QUERY) &&
              (d_clamp != D_W'(1)) && out_ok) begin
            state <= S_GATE;
          end
        end
        S_GATE: state <= S_PA;
        S_PA: begin
          // a gate with no paths passes nothing down
          if (v_in != '0) begin
            state <= S_PAW;
          end else if ((top || last_gate) && (cur_lay == '0)) begin
            state <= S_SCAN;
          end else begin
            state <= S_GATE;
          end
        end
        S_PAW: state <= S_PBW;
        S_PBW: begin
          if ((top || last_gate) && (cur_lay == '0)) begin
            state <= S_SCAN;
          end else begin
            state <= S_GATE;
          end
        end
        S_SCAN: begin
          if (last_scan) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Walk position, operands and result
  always_ff @(posedge clk) begin
    if (accept && (kind == lcpc_pkg::KIND_QUERY)) begin
      n_q      <= n_clamp;
      w_q      <= w_clamp;
      cur_lay  <= L_W'(32'(d_clamp) - 1);
      cur_g    <= G_W'(output_index);
      top      <= 1'b1;
      best     <= '0;
      scan_idx <= '0;
      max_paths <= (d_clamp == D_W'(1)) ? lcpc_pkg::RESULT_W'(1) : '0;
    end
    if (state == S_PA) begin
      v      <= v_in;
      a_ok   <= a_info[CA_W];
      a_slot <= a_info[CA_W-1:0];
      b_ok   <= b_info[CA_W];
      b_slot <= b_info[CA_W-1:0];
      same   <= (pt_q[PW-1:0] == pt_q[PT_W-1:PW]);
    end
    if (state == S_PAW) begin
      a_sum <= sum_a;
    end
    // step to the next gate after its pushes, or after a zero count
    if ((state == S_PBW) || ((state == S_PA) && (v_in == '0))) begin
      if (top || last_gate) begin
        if (cur_lay != '0) begin
          cur_lay <= cur_lay - 1'b1;
        end
        cur_g <= '0;
        top   <= 1'b0;
      end else begin
        cur_g <= cur_g + 1'b1;
      end
    end
    if (state == S_SCAN) begin
      scan_idx <= scan_idx + 1'b1;
      if (cmp_pend) begin
        best <= best_fin;
      end
    end
    if (state == S_DRAIN) begin
      max_paths <= lcpc_pkg::RESULT_W'(best_fin);
    end
  end

  `LCPC_ASSERT_SAME(a_done_idle, clk, rst, done, state == S_IDLE, "result strobe while walking")
  `LCPC_ASSERT_NEXT(a_load_silent, clk, rst, accept && kind == lcpc_pkg::KIND_LOAD, !done, "load gave a result")
  `LCPC_ASSERT_NEXT(a_query_moves, clk, rst, accept && kind == lcpc_pkg::KIND_QUERY, busy || done, "query neither ran nor answered")
  `LCPC_ASSERT_SAME(a_no_wr_on_fetch, clk, rst, state == S_GATE || state == S_SCAN, !cnt_cmd.wr, "count write during a fetch")

endmodule

[verif/layered_circuit_path_count_max_test.sv]
`timescale 1ns / 100ps

module layered_circuit_path_count_max_test;
  import lcpc_pkg::*;

  localparam int GATE_SLOTS   = MAX_DEPTH_DEF * MAX_WIDTH_DEF;
  localparam int COUNT_SLOTS  = MAX_INPUTS_DEF + GATE_SLOTS;
  localparam longint unsigned COUNT_CEIL = (64'd1 << COUNT_BITS_DEF) - 1;
  localparam int ITEM_TARGET  = 750;
  localparam int LIMIT_CYCLES = 4_000_000;
  localparam int SETTLE_CYCLES = 20;

  // One request as the sender sees it
  typedef struct {
    logic                kind;
    logic [LAYER_W-1:0]  layer;
    logic [GATE_W-1:0]   gate;
    logic [PARENT_W-1:0] parent_a;
    logic [PARENT_W-1:0] parent_b;
    logic [INDEX_W-1:0]  output_index;
    bit                  wait_drain;
  } circuit_req_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  kind = KIND_LOAD;
  logic [LAYER_W-1:0]    layer = '0;
  logic [GATE_W-1:0]     gate = '0;
  logic [PARENT_W-1:0]   parent_a = '0;
  logic [PARENT_W-1:0]   parent_b = '0;
  logic [INDEX_W-1:0]    output_index = '0;
  logic                  done;
  logic [RESULT_W-1:0]   max_paths;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_NUM_INPUTS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  layered_circuit_path_count_max u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .layer        (layer),
    .gate         (gate),
    .parent_a     (parent_a),
    .parent_b     (parent_b),
    .output_index (output_index),
    .done         (done),
    .max_paths    (max_paths),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  circuit_req_t        circuit_req_q[$];
  logic [RESULT_W-1:0] expected_max_q[$];
  int                  failures = 0;
  int                  items_made = 0;
  int                  gap_left = 0;
  bit                  sender_fast = 1'b0;
  longint unsigned     cycle_count = 0;

  // Shadow of the registers, raw as written
  int unsigned reg_inputs = NUM_INPUTS_RST;
  int unsigned reg_depth  = DEPTH_RST;
  int unsigned reg_width  = WIDTH_RST;

  // Predictor state: gate parents and per-node path tallies
  logic [PARENT_W-1:0] parent_a_of [GATE_SLOTS];
  logic [PARENT_W-1:0] parent_b_of [GATE_SLOTS];
  int unsigned         path_tally  [COUNT_SLOTS];

  // Generator's view of which gates have parents loaded
  bit gate_loaded [GATE_SLOTS];

  function automatic int unsigned clamp_reg(input int unsigned v, input int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Add v paths to parent p of a gate in layer lay, saturating
  function automatic void credit_parent(input int unsigned lay, input int unsigned p,
                                        input int unsigned v, input int unsigned n,
                                        input int unsigned w);
    int unsigned     slot;
    longint unsigned sum;
    if (lay == 0) begin
      if (p >= n) return;
      slot = p;
    end else begin
      if (p >= w) return;
      slot = MAX_INPUTS_DEF + (lay - 1) * MAX_WIDTH_DEF + p;
    end
    sum = longint'(path_tally[slot]) + v;
    path_tally[slot] = (sum > COUNT_CEIL) ? COUNT_CEIL : sum;
  endfunction

  // Largest path count from top gate oi down to any primary input
  function automatic logic [RESULT_W-1:0] count_max_paths(input int unsigned oi);
    int unsigned n, d, w, lay, g, at, best;
    n = clamp_reg(reg_inputs, MAX_INPUTS_DEF);
    d = clamp_reg(reg_depth, MAX_DEPTH_DEF);
    w = clamp_reg(reg_width, MAX_WIDTH_DEF);
    foreach (path_tally[i]) path_tally[i] = 0;
    if (d == 1) return 1;
    if (oi >= w) return 0;
    at = (d - 1) * MAX_WIDTH_DEF + oi;
    credit_parent(d - 1, parent_a_of[at], 1, n, w);
    credit_parent(d - 1, parent_b_of[at], 1, n, w);
    // walk down: layer lay-1 takes what layer lay handed it
    for (lay = d - 1; lay > 0; lay--) begin
      for (g = 0; g < w; g++) begin
        at = (lay - 1) * MAX_WIDTH_DEF + g;
        credit_parent(lay - 1, parent_a_of[at], path_tally[MAX_INPUTS_DEF + at], n, w);
        credit_parent(lay - 1, parent_b_of[at], path_tally[MAX_INPUTS_DEF + at], n, w);
      end
    end
    best = 0;
    for (g = 0; g < n; g++)
      if (path_tally[g] > best) best = path_tally[g];
    return best[RESULT_W-1:0];
  endfunction

  // Request generation
  function automatic void push_req(input circuit_req_t r);
    r.wait_drain = (items_made % 40) == 39;
    items_made++;
    circuit_req_q.push_back(r);
  endfunction

  function automatic circuit_req_t random_req();
    circuit_req_t r;
    r.kind         = $urandom_range(0, 1);
    r.layer        = $urandom_range(0, 7);
    r.gate         = $urandom_range(0, 15);
    r.parent_a     = $urandom_range(0, 15);
    r.parent_b     = $urandom_range(0, 15);
    r.output_index = $urandom_range(0, 15);
    r.wait_drain   = 1'b0;
    return r;
  endfunction

  function automatic void add_load(input int unsigned lay, input int unsigned g,
                                   input int unsigned pa, input int unsigned pb);
    circuit_req_t r;
    r          = random_req();
    r.kind     = KIND_LOAD;
    r.layer    = lay;
    r.gate     = g;
    r.parent_a = pa;
    r.parent_b = pb;
    gate_loaded[lay * MAX_WIDTH_DEF + g] = 1'b1;
    push_req(r);
  endfunction

  // Mostly a parent that exists, now and then any index
  function automatic int unsigned pick_parent(input int unsigned lay);
    int unsigned lim;
    lim = (lay == 0) ? clamp_reg(reg_inputs, MAX_INPUTS_DEF)
                     : clamp_reg(reg_width, MAX_WIDTH_DEF);
    if ($urandom_range(0, 5) == 0) return $urandom_range(0, 15);
    return $urandom_range(0, lim - 1);
  endfunction

  // Query; first load any gate the walk would read that was never loaded
  function automatic void add_query(input int unsigned oi);
    circuit_req_t r;
    int unsigned  d, w, lay, g;
    d = clamp_reg(reg_depth, MAX_DEPTH_DEF);
    w = clamp_reg(reg_width, MAX_WIDTH_DEF);
    if (d > 1 && oi < w) begin
      for (lay = 0; lay < d - 1; lay++)
        for (g = 0; g < w; g++)
          if (!gate_loaded[lay * MAX_WIDTH_DEF + g])
            add_load(lay, g, pick_parent(lay), pick_parent(lay));
      if (!gate_loaded[(d - 1) * MAX_WIDTH_DEF + oi])
        add_load(d - 1, oi, pick_parent(d - 1), pick_parent(d - 1));
    end
    r              = random_req();
    r.kind         = KIND_QUERY;
    r.output_index = oi;
    push_req(r);
  endfunction

  function automatic void fill_phase(input int count);
    int unsigned d, w, lay;
    d = clamp_reg(reg_depth, MAX_DEPTH_DEF);
    w = clamp_reg(reg_width, MAX_WIDTH_DEF);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < 55) begin
        lay = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(0, d - 1);
        add_load(lay,
                 ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(0, w - 1),
                 pick_parent(lay), pick_parent(lay));
      end else begin
        add_query(($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : $urandom_range(0, w - 1));
      end
    end
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_NUM_INPUTS: reg_inputs = val & 5'h1f;
      REG_DEPTH:      reg_depth  = val & 4'hf;
      REG_WIDTH:      reg_width  = val & 5'h1f;
      default: ;
    endcase
  endtask

  // Block idle: nothing queued, nothing owed, no request pending
  task automatic wait_idle();
    while (circuit_req_q.size() != 0 || expected_max_q.size() != 0 || start || busy)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Driver: present requests, model each one as it is taken
  always @(posedge clk) begin : drive_proc
    circuit_req_t nxt;
    if (rst) begin
      start    <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        if (kind == KIND_LOAD) begin
          parent_a_of[{layer, gate}] = parent_a;
          parent_b_of[{layer, gate}] = parent_b;
        end else begin
          expected_max_q.push_back(count_max_paths(output_index));
        end
      end
      if (!start || !busy) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          start    <= 1'b0;
        end else if (circuit_req_q.size() != 0 &&
                     !(circuit_req_q[0].wait_drain &&
                       (expected_max_q.size() != 0 || busy))) begin
          nxt          = circuit_req_q.pop_front();
          kind         <= nxt.kind;
          layer        <= nxt.layer;
          gate         <= nxt.gate;
          parent_a     <= nxt.parent_a;
          parent_b     <= nxt.parent_b;
          output_index <= nxt.output_index;
          start        <= 1'b1;
          gap_left     <= sender_fast ? 0 : $urandom_range(0, 19);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each strobed result with the oldest expectation
  always @(posedge clk) begin : check_proc
    logic [RESULT_W-1:0] want;
    if (!rst && done) begin
      if (expected_max_q.size() == 0) begin
        $error("max_paths: no query outstanding, actual %0d", max_paths);
        failures++;
      end else begin
        want = expected_max_q.pop_front();
        if (max_paths !== want) begin
          $error("max_paths: expected %0d, actual %0d", want, max_paths);
          failures++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("layered_circuit_path_count_max: mismatch");
      $finish;
    end
  end

  initial begin : stim_proc
    int unsigned fix_n [6] = '{16, 1, 0, 31, 7, 9};
    int unsigned fix_d [6] = '{8, 2, 0, 15, 1, 18};
    int unsigned fix_w [6] = '{16, 1, 0, 31, 5, 4};
    int unsigned n, d, w;
    int          phase;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset sizes (5 inputs, 3 layers, 3 wide)
    add_load(0, 0, 0, 4);
    add_load(0, 1, 4, 4);
    add_load(0, 2, 15, 5);
    add_load(1, 0, 0, 1);
    add_load(1, 1, 2, 2);
    add_load(1, 2, 15, 3);
    add_load(2, 0, 0, 1);
    add_load(2, 1, 1, 2);
    add_load(2, 2, 2, 2);
    add_load(7, 15, 15, 15);
    add_query(0);
    add_query(1);
    add_query(2);
    add_query(3);
    add_query(15);
    add_load(0, 0, 4, 4);
    add_query(2);
    wait_idle();

    // Random phases, extremes first
    phase = 0;
    while (items_made < ITEM_TARGET) begin
      if (phase < 6) begin
        n = fix_n[phase];
        d = fix_d[phase];
        w = fix_w[phase];
      end else begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
        d = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 8);
        w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
      end
      write_reg(REG_NUM_INPUTS, n);
      write_reg(REG_DEPTH, d);
      write_reg(REG_WIDTH, w);
      sender_fast = (phase % 3) == 1;
      fill_phase($urandom_range(15, 45));
      if (phase == 4) add_query(15);
      wait_idle();
      phase++;
    end

    if (failures == 0) begin
      $display("layered_circuit_path_count_max: match");
    end else begin
      $display("layered_circuit_path_count_max: mismatch");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/lcpc_pkg.sv
src/lcpc_ram.sv
src/lcpc_count_store.sv
src/layered_circuit_path_count_max.sv
verif/layered_circuit_path_count_max_test.sv
